// ----- rtl/core/msd_pkg.sv -----
package msd_pkg;

   localparam int NUM_SENSORS = 64;
   localparam int SENSOR_IDX_W = 6;
   localparam int SAMPLE_W = 8;
   localparam int HIST_W = 4;
   localparam int COUNT_W = 8;
   localparam int ADDR_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int IDX_EXT_W = ((ADDR_W > SENSOR_IDX_W) ? ADDR_W : SENSOR_IDX_W) + 1;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd32;
   localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
   localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd128;
   localparam logic signed [COUNT_W-1:0] COUNT_ONE = 8'sd1;
   localparam logic signed [COUNT_W-1:0] COUNT_MINUS_ONE = -8'sd1;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [SENSOR_IDX_W-1:0] sensor_index;
      logic [SAMPLE_W-1:0]     sample;
   } req_type;

   typedef struct packed {
      logic [SENSOR_IDX_W-1:0]   sensor_index_out;
      logic                      pressed;
      logic signed [COUNT_W-1:0] run_count;
   } rsp_type;

   typedef struct packed {
      logic [HIST_W-1:0]         hist;
      logic signed [COUNT_W-1:0] count;
   } entry_type;

endpackage

// ----- rtl/core/msd_ram.sv -----
module msd_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read-first: a read and a write to one address in the same cycle return the old word
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

endmodule

// ----- rtl/core/multichannel_sensor_debouncer.sv -----
// pipeline: a sample beat is registered with the memory read, then into the response register
// throughput: one beat per cycle unless a held response stalls stage 1; the per-sensor
//   read-modify-write goes through a registered-read memory with a one-entry write bypass
// reset: threshold returns to 32; histories and counters read as zero at once
//   through per-sensor valid flags, with no clearing pass
module multichannel_sensor_debouncer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  msd_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output msd_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [msd_pkg::SAMPLE_W-1:0]  csr_wdata
);

   logic [msd_pkg::SAMPLE_W-1:0] threshold_ff;

   logic                              s1_valid_ff;
   logic                              s1_func_ff;
   logic                              s1_on_ff;
   logic                              s1_in_range_ff;
   logic [msd_pkg::SENSOR_IDX_W-1:0]  s1_idx_ff;
   logic [msd_pkg::ADDR_W-1:0]        s1_addr_ff;

   logic                              fwd_valid_ff;
   logic [msd_pkg::ADDR_W-1:0]        fwd_addr_ff;
   msd_pkg::entry_type                fwd_entry_ff;

   logic [msd_pkg::NUM_SENSORS-1:0]   hist_vld_ff;
   logic [msd_pkg::NUM_SENSORS-1:0]   cnt_vld_ff;

   logic                              rsp_valid_ff;
   msd_pkg::rsp_type                  rsp_data_ff;

   logic                              accept;
   logic                              s1_adv;
   logic                              do_write;
   logic                              do_clear;
   logic [msd_pkg::IDX_EXT_W-1:0]     req_idx_ext;
   logic [msd_pkg::ADDR_W-1:0]        req_addr;
   logic                              req_in_range;
   logic [$bits(msd_pkg::entry_type)-1:0] ram_rdata;
   msd_pkg::entry_type                ram_entry;
   msd_pkg::entry_type                old_entry;
   msd_pkg::entry_type                new_entry;
   logic                              fwd_hit;
   logic                              pressed_in;
   logic signed [msd_pkg::COUNT_W-1:0] count_in;

   assign csr_ready = 1'b1;
   assign s1_adv    = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_ready = s1_adv;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_idx_ext  = msd_pkg::IDX_EXT_W'(req_data.sensor_index);
   assign req_in_range = req_idx_ext < msd_pkg::IDX_EXT_W'(msd_pkg::NUM_SENSORS);
   assign req_addr     = req_idx_ext[msd_pkg::ADDR_W-1:0];

   assign do_clear = s1_adv && s1_valid_ff && (s1_func_ff == msd_pkg::FUNC_CLEAR);
   assign do_write = s1_adv && s1_valid_ff && (s1_func_ff == msd_pkg::FUNC_SAMPLE)
                     && s1_in_range_ff;

   msd_ram #(
      .WIDTH ($bits(msd_pkg::entry_type)),
      .DEPTH (msd_pkg::NUM_SENSORS)
   ) u_ram (
      .clock    (clock),
      .we       (do_write),
      .waddr    (s1_addr_ff),
      .wdata    (new_entry),
      .re       (accept),
      .raddr    (req_addr),
      .rdata_ff (ram_rdata)
   );

   // entry lookup: bypass the word written in the read cycle, else memory masked by valid flags
   always_comb begin
      ram_entry = msd_pkg::entry_type'(ram_rdata);
      fwd_hit   = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
      if (fwd_hit) begin
         old_entry = fwd_entry_ff;
      end else begin
         old_entry.hist  = hist_vld_ff[s1_addr_ff] ? ram_entry.hist : '0;
         old_entry.count = cnt_vld_ff[s1_addr_ff] ? ram_entry.count : '0;
      end
   end

   always_comb begin
      new_entry.hist = {old_entry.hist[msd_pkg::HIST_W-2:0], s1_on_ff};
      pressed_in     = |new_entry.hist;
      if (pressed_in) begin
         if (old_entry.count <= 0) begin
            count_in = msd_pkg::COUNT_ONE;
         end else if (old_entry.count == msd_pkg::COUNT_MAX) begin
            count_in = msd_pkg::COUNT_MAX;
         end else begin
            count_in = old_entry.count + msd_pkg::COUNT_ONE;
         end
      end else begin
         if (old_entry.count >= 0) begin
            count_in = msd_pkg::COUNT_MINUS_ONE;
         end else if (old_entry.count == msd_pkg::COUNT_MIN) begin
            count_in = msd_pkg::COUNT_MIN;
         end else begin
            count_in = old_entry.count - msd_pkg::COUNT_ONE;
         end
      end
      new_entry.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= msd_pkg::THRESHOLD_RESET;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         hist_vld_ff  <= '0;
         cnt_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_wdata;
         end
         if (s1_adv) begin
            s1_valid_ff <= accept;
         end
         if (do_write) begin
            fwd_valid_ff            <= 1'b1;
            hist_vld_ff[s1_addr_ff] <= 1'b1;
            cnt_vld_ff[s1_addr_ff]  <= 1'b1;
         end
         if (do_clear) begin
            hist_vld_ff <= '0;
         end
         if (do_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff     <= req_data.func;
         s1_on_ff       <= req_data.sample > threshold_ff;
         s1_in_range_ff <= req_in_range;
         s1_idx_ff      <= req_data.sensor_index;
         s1_addr_ff     <= req_addr;
      end
      if (do_write) begin
         fwd_addr_ff  <= s1_addr_ff;
         fwd_entry_ff <= new_entry;
         rsp_data_ff.sensor_index_out <= s1_idx_ff;
         rsp_data_ff.pressed          <= pressed_in;
         rsp_data_ff.run_count        <= count_in;
      end
      if (do_clear) begin
         fwd_entry_ff.hist <= '0;
      end
   end

endmodule
